@@ sv/bni_pkg.sv @@
// ============================================================================
// bni_pkg
// Shared types and constants of the batch-norm inference block.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package bni_pkg;

    localparam int BN_MAX_CHANNELS = 64;
    localparam int BN_CHAN_W       = 6;
    localparam int BN_COUNT_W      = 7;
    localparam int BN_SAMPLE_BITS  = 16;
    localparam int BN_PARAM_W      = 16;
    localparam int BN_SCALE_W      = 32;
    localparam int BN_DIFF_W       = BN_SAMPLE_BITS + 1;
    localparam int BN_PROD_W       = BN_DIFF_W + BN_SCALE_W;
    localparam int BN_FRAC_SHIFT   = 24;
    localparam int BN_SHIFTED_W    = BN_PROD_W - BN_FRAC_SHIFT;
    localparam int BN_RESULT_W     = BN_SHIFTED_W + 1;

    localparam int BN_APB_ADDR_W   = 3;
    localparam int BN_APB_DATA_W   = 32;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_SAMPLE = 1'b1
    } t_bn_cmd;

    typedef enum logic {
        REG_CHANNEL_COUNT = 1'b0,
        REG_UNUSED        = 1'b1
    } t_bn_reg;

    typedef struct packed {
        t_bn_cmd                         command;
        logic [BN_CHAN_W-1:0]            load_channel;
        logic signed [BN_PARAM_W-1:0]    load_mean;
        logic signed [BN_PARAM_W-1:0]    load_istd;
        logic signed [BN_PARAM_W-1:0]    load_gamma;
        logic signed [BN_PARAM_W-1:0]    load_beta;
        logic signed [BN_SAMPLE_BITS-1:0] sample;
        logic                            first_of_tensor;
    } t_bn_in;

    typedef struct packed {
        logic signed [BN_SAMPLE_BITS-1:0] normalized;
        logic [BN_CHAN_W-1:0]            channel;
        logic                            saturated;
    } t_bn_out;

    typedef struct packed {
        logic                         en;
        logic [BN_CHAN_W-1:0]         channel;
        logic signed [BN_PARAM_W-1:0] mean;
        logic signed [BN_PARAM_W-1:0] istd;
        logic signed [BN_PARAM_W-1:0] gamma;
        logic signed [BN_PARAM_W-1:0] beta;
    } t_bn_load;

    typedef struct packed {
        logic                         en;
        logic [BN_CHAN_W-1:0]         channel;
    } t_bn_lookup;

    typedef struct packed {
        logic signed [BN_PARAM_W-1:0] mean;
        logic signed [BN_SCALE_W-1:0] scale;
        logic signed [BN_PARAM_W-1:0] beta;
    } t_bn_params;

endpackage

`default_nettype wire

@@ sv/batch_norm_inference.sv @@
// ============================================================================
// batch_norm_inference
// Per-channel fixed-point batch normalization for inference.
// ============================================================================
// channel  direction  handshake                 payload
// in       input      i_in_valid / o_in_ready   i_in_data  (t_bn_in)
// out      output     o_out_valid / i_out_ready o_out_data (t_bn_out)
// apb      input      psel / penable / pready   paddr, pwdata, prdata
//
// one item per cycle unless the output stalls; a sample passes the stage 1, stage 2 and output registers
// stages: parameter lookup, 17x32 multiply, shift/offset/saturate in the output register
// loads write the parameter memory at their transfer and give no result
// each stage advances when the stage after it is empty or moving on
// synchronous active-low reset clears valids and counter and loads 1 into the channel count
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module batch_norm_inference (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire bni_pkg::t_bn_in                 i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output bni_pkg::t_bn_out                     o_out_data,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bni_pkg::BN_APB_ADDR_W-1:0] paddr,
    input  wire logic [bni_pkg::BN_APB_DATA_W-1:0] pwdata,
    output logic [bni_pkg::BN_APB_DATA_W-1:0]    prdata,
    output logic                                 pready
);
    import bni_pkg::*;

    localparam logic [BN_COUNT_W-1:0] MaxCount = BN_COUNT_W'(BN_MAX_CHANNELS);
    localparam logic signed [BN_RESULT_W-1:0] SatMax =
        BN_RESULT_W'((2 ** (BN_SAMPLE_BITS - 1)) - 1);
    localparam logic signed [BN_RESULT_W-1:0] SatMin = -SatMax - BN_RESULT_W'(1);

    logic [BN_COUNT_W-1:0]            r_channel_count;
    logic [BN_CHAN_W-1:0]             r_counter;
    logic [BN_CHAN_W-1:0]             n_counter;

    logic                             w_en1;
    logic                             w_en2;
    logic                             w_en3;
    logic                             w_in_xfer;
    logic                             w_sample_xfer;
    logic                             w_cfg_write;
    t_bn_reg                          w_reg_sel;

    logic [BN_COUNT_W-1:0]            w_count_eff;
    logic [BN_CHAN_W-1:0]             w_ch_base;
    logic [BN_CHAN_W-1:0]             w_ch;
    logic [BN_COUNT_W-1:0]            w_ch_inc;

    t_bn_load                         w_load;
    t_bn_lookup                       w_lookup;
    t_bn_params                       w_params;

    logic                             r_s1_valid;
    logic signed [BN_SAMPLE_BITS-1:0] r_s1_sample;
    logic [BN_CHAN_W-1:0]             r_s1_channel;

    logic                             r_s2_valid;
    logic signed [BN_PROD_W-1:0]      r_s2_product;
    logic signed [BN_PARAM_W-1:0]     r_s2_beta;
    logic [BN_CHAN_W-1:0]             r_s2_channel;

    logic                             r_out_valid;
    t_bn_out                          r_out_data;
    t_bn_out                          n_out_data;

    logic signed [BN_DIFF_W-1:0]      w_diff;
    logic signed [BN_PROD_W-1:0]      w_product;
    logic signed [BN_SHIFTED_W-1:0]   w_shifted;
    logic signed [BN_RESULT_W-1:0]    w_result;

    // handshake
    assign w_en3         = !r_out_valid || i_out_ready;
    assign w_en2         = !r_s2_valid || w_en3;
    assign w_en1         = !r_s1_valid || w_en2;
    assign o_in_ready    = w_en1;
    assign w_in_xfer     = i_in_valid && w_en1;
    assign w_sample_xfer = w_in_xfer && (i_in_data.command == CMD_SAMPLE);

    // configuration
    assign pready      = 1'b1;
    assign w_reg_sel   = t_bn_reg'(paddr[BN_APB_ADDR_W-1]);
    assign w_cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= BN_COUNT_W'(1);
        end else if (w_cfg_write) begin
            unique case (w_reg_sel)
                REG_CHANNEL_COUNT: r_channel_count <= pwdata[BN_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_sel)
            REG_CHANNEL_COUNT: prdata = BN_APB_DATA_W'(r_channel_count);
            default:           prdata = '0;
        endcase
    end

    // channel counter
    always_comb begin
        if (r_channel_count == '0) begin
            w_count_eff = BN_COUNT_W'(1);
        end else if (r_channel_count > MaxCount) begin
            w_count_eff = MaxCount;
        end else begin
            w_count_eff = r_channel_count;
        end
        w_ch_base = i_in_data.first_of_tensor ? '0 : r_counter;
        w_ch      = ({1'b0, w_ch_base} >= w_count_eff) ? '0 : w_ch_base;
        w_ch_inc  = {1'b0, w_ch} + BN_COUNT_W'(1);
        n_counter = (w_ch_inc >= w_count_eff) ? '0 : w_ch_inc[BN_CHAN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
        end else if (w_sample_xfer) begin
            r_counter <= n_counter;
        end
    end

    // parameter memory
    always_comb begin
        w_load.en        = w_in_xfer && (i_in_data.command == CMD_LOAD);
        w_load.channel   = i_in_data.load_channel;
        w_load.mean      = i_in_data.load_mean;
        w_load.istd      = i_in_data.load_istd;
        w_load.gamma     = i_in_data.load_gamma;
        w_load.beta      = i_in_data.load_beta;
        w_lookup.en      = w_en1;
        w_lookup.channel = w_ch;
    end

    bni_param_store u_param_store (
        .i_clk    (i_clk),
        .i_load   (w_load),
        .i_lookup (w_lookup),
        .o_params (w_params)
    );

    // stage 1: sample waits for its parameters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en1) begin
            r_s1_valid <= w_sample_xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_sample  <= i_in_data.sample;
            r_s1_channel <= w_ch;
        end
    end

    // stage 2: centered sample times scale
    assign w_diff    = BN_DIFF_W'(r_s1_sample) - BN_DIFF_W'(w_params.mean);
    assign w_product = BN_PROD_W'(w_diff) * BN_PROD_W'(w_params.scale);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_s2_product <= w_product;
            r_s2_beta    <= w_params.beta;
            r_s2_channel <= r_s1_channel;
        end
    end

    // stage 3: floor shift, offset, saturate
    always_comb begin
        w_shifted             = BN_SHIFTED_W'(r_s2_product >>> BN_FRAC_SHIFT);
        w_result              = BN_RESULT_W'(w_shifted) - BN_RESULT_W'(r_s2_beta);
        n_out_data.channel    = r_s2_channel;
        if (w_result > SatMax) begin
            n_out_data.normalized = SatMax[BN_SAMPLE_BITS-1:0];
            n_out_data.saturated  = 1'b1;
        end else if (w_result < SatMin) begin
            n_out_data.normalized = SatMin[BN_SAMPLE_BITS-1:0];
            n_out_data.saturated  = 1'b1;
        end else begin
            n_out_data.normalized = w_result[BN_SAMPLE_BITS-1:0];
            n_out_data.saturated  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en3) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

@@ sv/bni_param_store.sv @@
// ============================================================================
// bni_param_store
// Per-channel parameter memory; forms the scale on load, registered lookup.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bni_param_store (
    input  wire logic               i_clk,
    input  wire bni_pkg::t_bn_load   i_load,
    input  wire bni_pkg::t_bn_lookup i_lookup,
    output bni_pkg::t_bn_params      o_params
);
    import bni_pkg::*;

    t_bn_params                   r_mem [BN_MAX_CHANNELS];
    t_bn_params                   r_rd_data;
    t_bn_params                   w_wr_data;
    logic signed [BN_SCALE_W-1:0] w_scale;

    // Q4.12 * Q4.12 gives Q8.24
    assign w_scale = BN_SCALE_W'(i_load.istd) * BN_SCALE_W'(i_load.gamma);

    always_comb begin
        w_wr_data.mean  = i_load.mean;
        w_wr_data.scale = w_scale;
        w_wr_data.beta  = i_load.beta;
    end

    always_ff @(posedge i_clk) begin
        if (i_load.en) begin
            r_mem[i_load.channel] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_lookup.en) begin
            r_rd_data <= r_mem[i_lookup.channel];
        end
    end

    assign o_params = r_rd_data;

endmodule

`default_nettype wire

@@ sv/bni_checker.sv @@
// ============================================================================
// bni_checker
// Port-level checks of the batch-norm inference block.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bni_checker (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             o_in_ready,
    input  wire logic             o_out_valid,
    input  wire logic             i_out_ready,
    input  wire bni_pkg::t_bn_out o_out_data
);
    import bni_pkg::*;

    localparam logic [BN_SAMPLE_BITS-1:0] OutMax = {1'b0, {(BN_SAMPLE_BITS-1){1'b1}}};
    localparam logic [BN_SAMPLE_BITS-1:0] OutMin = {1'b1, {(BN_SAMPLE_BITS-1){1'b0}}};

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // an empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output");

    // clipped results sit at a rail
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.saturated |->
            (o_out_data.normalized == OutMax) || (o_out_data.normalized == OutMin))
        else $error("saturation flag without rail value");

    // reset empties the pipeline
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind batch_norm_inference bni_checker u_bni_checker (.*);

`default_nettype wire
